/* hw/rtl/rgbxy_pkg.sv */
// Package: payload types, matrix coefficients and sRGB linearization table.
`timescale 1ns / 1ps
package rgbxy_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LIN_BITS      = 24;
    localparam int LIN_W         = LIN_BITS + 1;
    localparam int COEF_W        = 20;
    localparam int PROD_W        = LIN_W + COEF_W;
    localparam int SUM_W         = 46;
    localparam int OUT_W         = 16;

    localparam logic [63:0] T_DEN   = 64'd269025;
    localparam logic [63:0] LIN_DEN = 64'd329460;
    localparam logic [63:0] T_DEN2  = T_DEN * T_DEN;

    localparam logic [COEF_W-1:0] MXR = 20'd649926;
    localparam logic [COEF_W-1:0] MXG = 20'd103455;
    localparam logic [COEF_W-1:0] MXB = 20'd197109;
    localparam logic [COEF_W-1:0] MYR = 20'd234327;
    localparam logic [COEF_W-1:0] MYG = 20'd743075;
    localparam logic [COEF_W-1:0] MYB = 20'd22598;
    localparam logic [COEF_W-1:0] MZG = 20'd53077;
    localparam logic [COEF_W-1:0] MZB = 20'd1035763;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] chroma_x;
        logic [OUT_W-1:0] chroma_y;
        logic             black_input;
    } chroma_out_t;

    typedef struct packed {
        logic             valid;
        logic             black;
        logic [SUM_W-1:0] num_x;
        logic [SUM_W-1:0] num_y;
        logic [SUM_W-1:0] den;
    } sums_t;

    typedef logic [LIN_W-1:0] lin_table_t [256];

    // Linear light of one 8-bit code in Q1.24, evaluated at elaboration only.
    function automatic logic [LIN_W-1:0] lin_value(input logic [7:0] v);
        logic [191:0] lhs;
        logic [191:0] rhs;
        logic [63:0]  n;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  res;
        int           i;
        int           j;
        if (v <= 8'd10)
        begin
            res = ((64'(v) * 64'd100) << LIN_BITS) / LIN_DEN;
        end
        else
        begin
            n  = 64'd1000 * 64'(v) + 64'd14025;
            lo = 64'd0;
            hi = 64'd1 << LIN_BITS;
            for (i = 0; i < 32; i++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi + 64'd1) >> 1;
                    lhs = 192'(mid);
                    for (j = 0; j < 4; j++)
                    begin
                        lhs = lhs * 192'(mid);
                    end
                    lhs = lhs * 192'(T_DEN2);
                    rhs = (192'(n) * 192'(n)) << 120;
                    if (lhs <= rhs)
                    begin
                        lo = mid;
                    end
                    else
                    begin
                        hi = mid - 64'd1;
                    end
                end
            end
            res = (lo * n * n) / T_DEN2;
        end
        return res[LIN_W-1:0];
    endfunction

    function automatic lin_table_t build_lin_table();
        lin_table_t t;
        int         k;
        for (k = 0; k < 256; k++)
        begin
            t[k] = lin_value(8'(k));
        end
        return t;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

/* hw/rtl/rgbxy_linmat.sv */
// Linearization lookup, matrix products and X/Y/Z/sum accumulation (4 stages).
`timescale 1ns / 1ps
module rgbxy_linmat
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rgbxy_pkg::pix_in_t in_data,
    output rgbxy_pkg::sums_t  sums
);

    localparam int LinW  = rgbxy_pkg::LIN_W;
    localparam int ProdW = rgbxy_pkg::PROD_W;
    localparam int SumW  = rgbxy_pkg::SUM_W;

    logic [3:0] vld_reg;

    logic [LinW-1:0] lr_reg, lg_reg, lb_reg;
    logic [ProdW-1:0] pxr_reg, pxg_reg, pxb_reg;
    logic [ProdW-1:0] pyr_reg, pyg_reg, pyb_reg;
    logic [ProdW-1:0] pzg_reg, pzb_reg;
    logic [SumW-1:0] x_reg, y_reg, z_reg;
    logic [SumW-1:0] sx_reg, sy_reg, s_reg;
    logic [SumW-1:0] s_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    assign s_next = x_reg + y_reg + z_reg;

    always_ff @(posedge clk)
    begin
        lr_reg <= rgbxy_pkg::LIN_TABLE[in_data.red];
        lg_reg <= rgbxy_pkg::LIN_TABLE[in_data.green];
        lb_reg <= rgbxy_pkg::LIN_TABLE[in_data.blue];

        pxr_reg <= ProdW'(lr_reg) * ProdW'(rgbxy_pkg::MXR);
        pxg_reg <= ProdW'(lg_reg) * ProdW'(rgbxy_pkg::MXG);
        pxb_reg <= ProdW'(lb_reg) * ProdW'(rgbxy_pkg::MXB);
        pyr_reg <= ProdW'(lr_reg) * ProdW'(rgbxy_pkg::MYR);
        pyg_reg <= ProdW'(lg_reg) * ProdW'(rgbxy_pkg::MYG);
        pyb_reg <= ProdW'(lb_reg) * ProdW'(rgbxy_pkg::MYB);
        pzg_reg <= ProdW'(lg_reg) * ProdW'(rgbxy_pkg::MZG);
        pzb_reg <= ProdW'(lb_reg) * ProdW'(rgbxy_pkg::MZB);

        x_reg <= SumW'(pxr_reg) + SumW'(pxg_reg) + SumW'(pxb_reg);
        y_reg <= SumW'(pyr_reg) + SumW'(pyg_reg) + SumW'(pyb_reg);
        z_reg <= SumW'(pzg_reg) + SumW'(pzb_reg);

        sx_reg <= x_reg;
        sy_reg <= y_reg;
        s_reg  <= s_next;
    end

    assign sums.valid = vld_reg[3];
    assign sums.black = (s_reg == '0);
    assign sums.num_x = sx_reg;
    assign sums.num_y = sy_reg;
    assign sums.den   = s_reg;

endmodule

/* hw/rtl/rgbxy_divider.sv */
// Pipelined restoring divider for x and y, one quotient bit per stage, then rounding.
`timescale 1ns / 1ps
module rgbxy_divider
#(
    parameter int FRAC_BITS = rgbxy_pkg::FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rgbxy_pkg::sums_t       sums,
    output logic                   done,
    output rgbxy_pkg::chroma_out_t result
);

    localparam int SumW  = rgbxy_pkg::SUM_W;
    localparam int RemW  = SumW + 1;
    localparam int Steps = FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int ExtW  = (FRAC_BITS > rgbxy_pkg::OUT_W) ? FRAC_BITS : rgbxy_pkg::OUT_W;
    localparam int OutW  = rgbxy_pkg::OUT_W;

    logic [Steps:0]    vld_reg;
    logic              blk_reg [Steps+1];
    logic [RemW-1:0]   rx_reg  [Steps+1];
    logic [RemW-1:0]   ry_reg  [Steps+1];
    logic [RemW-1:0]   den_reg [Steps+1];
    logic [QW-1:0]     qx_reg  [Steps+1];
    logic [QW-1:0]     qy_reg  [Steps+1];

    logic              out_vld_reg;
    rgbxy_pkg::chroma_out_t out_reg;
    rgbxy_pkg::chroma_out_t out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[Steps-1:0], sums.valid};
            out_vld_reg <= vld_reg[Steps];
        end
    end

    // capture the request into stage zero
    always_ff @(posedge clk)
    begin
        blk_reg[0] <= sums.black;
        rx_reg[0]  <= RemW'(sums.num_x);
        ry_reg[0]  <= RemW'(sums.num_y);
        den_reg[0] <= RemW'(sums.den);
        qx_reg[0]  <= '0;
        qy_reg[0]  <= '0;
    end

    for (genvar k = 0; k < Steps; k++)
    begin : g_step
        logic [RemW-1:0] shx, shy;
        logic            gex, gey;

        assign shx = {rx_reg[k][RemW-2:0], 1'b0};
        assign shy = {ry_reg[k][RemW-2:0], 1'b0};
        assign gex = (shx >= den_reg[k]);
        assign gey = (shy >= den_reg[k]);

        always_ff @(posedge clk)
        begin
            blk_reg[k+1] <= blk_reg[k];
            den_reg[k+1] <= den_reg[k];
            rx_reg[k+1]  <= gex ? (shx - den_reg[k]) : shx;
            ry_reg[k+1]  <= gey ? (shy - den_reg[k]) : shy;
            qx_reg[k+1]  <= {qx_reg[k][QW-2:0], gex};
            qy_reg[k+1]  <= {qy_reg[k][QW-2:0], gey};
        end
    end

    // round half up and saturate to the Q0.FRAC_BITS range
    function automatic logic [OutW-1:0] round_sat(input logic [QW-1:0] q);
        logic [QW:0]          qr;
        logic [FRAC_BITS-1:0] sat;
        logic [ExtW-1:0]      ext;
        qr = ({1'b0, q} + (QW+1)'(1)) >> 1;
        if (qr[QW:FRAC_BITS] != '0)
        begin
            sat = '1;
        end
        else
        begin
            sat = qr[FRAC_BITS-1:0];
        end
        ext = ExtW'(sat);
        return ext[OutW-1:0];
    endfunction

    always_comb
    begin
        out_next.black_input = blk_reg[Steps];
        if (blk_reg[Steps])
        begin
            out_next.chroma_x = '0;
            out_next.chroma_y = '0;
        end
        else
        begin
            out_next.chroma_x = round_sat(qx_reg[Steps]);
            out_next.chroma_y = round_sat(qy_reg[Steps]);
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done   = out_vld_reg;
    assign result = out_reg;

endmodule

/* hw/rtl/rgb_to_cie_xy_chromaticity_core.sv */
// Top level: sRGB pixel to CIE xy chromaticity, fully pipelined.
//
//  channel   ports                 handshake
//  --------  --------------------  ----------------------------------------
//  request   start, busy, in_data  taken when start is high and busy is low
//  result    done, result          one-cycle strobe, no back-pressure
//
// One request per clock; busy is always low. The pipeline holds one table lookup
// stage, one multiply stage, two adder stages, FRAC_BITS + 2 divider stages
// (capture plus one quotient bit each) and one rounding/output stage. The
// divider chain sets the latency.
// Reset clears only the valid bits; payload registers run free.
`timescale 1ns / 1ps
module rgb_to_cie_xy_chromaticity_core
#(
    parameter int FRAC_BITS = rgbxy_pkg::FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  rgbxy_pkg::pix_in_t     in_data,
    output logic                   done,
    output rgbxy_pkg::chroma_out_t result
);

    rgbxy_pkg::sums_t sums;

    assign busy = 1'b0;

    rgbxy_linmat u_linmat
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .in_data  (in_data),
        .sums     (sums)
    );

    rgbxy_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sums   (sums),
        .done   (done),
        .result (result)
    );

endmodule

/* sim/rgb_to_cie_xy_chromaticity_checker.sv */
// Checker: predicts chromaticity for each accepted pixel and compares the results.
`timescale 1ns / 1ps
module rgb_to_cie_xy_chromaticity_checker
#(
    parameter int FRAC = rgbxy_pkg::FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  rgbxy_pkg::pix_in_t     in_data,
    input  logic                   done,
    input  rgbxy_pkg::chroma_out_t result,
    output int                     errors,
    output int                     pending
);

    logic [24:0]             lin_lut [256];
    rgbxy_pkg::chroma_out_t  chroma_q [$];

    // Largest q with q^5 * D^2 <= N^2 * 2^120, then scale by (N/D)^2.
    function automatic logic [24:0] srgb_to_linear(int code);
        logic [191:0] pow5;
        logic [191:0] bound;
        logic [63:0]  num;
        logic [63:0]  den2;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  val;
        den2 = 64'd269025 * 64'd269025;
        if (code <= 10)
        begin
            val = ((64'(code) * 64'd100) << 24) / 64'd329460;
        end
        else
        begin
            num = 64'd1000 * 64'(code) + 64'd14025;
            bound = (192'(num) * 192'(num)) << 120;
            lo = 0;
            hi = 64'd1 << 24;
            while (lo < hi)
            begin
                mid = (lo + hi + 64'd1) >> 1;
                pow5 = 192'(mid) * 192'(mid) * 192'(mid) * 192'(mid) * 192'(mid)
                       * 192'(den2);
                if (pow5 <= bound)
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
            val = (lo * num * num) / den2;
        end
        return val[24:0];
    endfunction

    // Restoring divide with one guard bit, round half up, saturate.
    function automatic logic [63:0] chroma_ratio(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] top;
        rem = num;
        quo = 0;
        top = (64'd1 << FRAC) - 64'd1;
        for (int i = 0; i < FRAC + 1; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        quo = (quo + 64'd1) >> 1;
        return (quo > top) ? top : quo;
    endfunction

    function automatic rgbxy_pkg::chroma_out_t predict_chroma(rgbxy_pkg::pix_in_t p);
        rgbxy_pkg::chroma_out_t c;
        logic [63:0] lr;
        logic [63:0] lg;
        logic [63:0] lb;
        logic [63:0] cx;
        logic [63:0] cy;
        logic [63:0] cz;
        logic [63:0] qx;
        logic [63:0] qy;
        lr = 64'(lin_lut[p.red]);
        lg = 64'(lin_lut[p.green]);
        lb = 64'(lin_lut[p.blue]);
        cx = 64'd649926 * lr + 64'd103455 * lg + 64'd197109 * lb;
        cy = 64'd234327 * lr + 64'd743075 * lg + 64'd22598 * lb;
        cz = 64'd53077 * lg + 64'd1035763 * lb;
        if (cx + cy + cz == 64'd0)
        begin
            c.chroma_x    = '0;
            c.chroma_y    = '0;
            c.black_input = 1'b1;
        end
        else
        begin
            qx = chroma_ratio(cx, cx + cy + cz);
            qy = chroma_ratio(cy, cx + cy + cz);
            c.chroma_x    = qx[15:0];
            c.chroma_y    = qy[15:0];
            c.black_input = 1'b0;
        end
        return c;
    endfunction

    initial
    begin
        errors = 0;
        for (int k = 0; k < 256; k++)
        begin
            lin_lut[k] = srgb_to_linear(k);
        end
    end

    assign pending = chroma_q.size();

    always @(posedge clk)
    begin
        rgbxy_pkg::chroma_out_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                chroma_q.push_back(predict_chroma(in_data));
            end
            if (done)
            begin
                if (chroma_q.size() == 0)
                begin
                    $display("%0t: result with no request waiting: %p", $time, result);
                    errors++;
                end
                else
                begin
                    want = chroma_q.pop_front();
                    if (result.chroma_x !== want.chroma_x)
                    begin
                        $display("%0t: chroma_x expected %0d actual %0d", $time,
                                 want.chroma_x, result.chroma_x);
                        errors++;
                    end
                    if (result.chroma_y !== want.chroma_y)
                    begin
                        $display("%0t: chroma_y expected %0d actual %0d", $time,
                                 want.chroma_y, result.chroma_y);
                        errors++;
                    end
                    if (result.black_input !== want.black_input)
                    begin
                        $display("%0t: black_input expected %0b actual %0b", $time,
                                 want.black_input, result.black_input);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

/* sim/tb.sv */
// Testbench top: clock, reset, pixel stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM       = 730;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    rgbxy_pkg::pix_in_t     in_data;
    logic                   done;
    rgbxy_pkg::chroma_out_t result;
    int                     errors;
    int                     pending;
    int                     idle_cycles;
    bit                     timed_out;

    rgb_to_cie_xy_chromaticity_core i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_data (in_data),
        .done    (done),
        .result  (result)
    );

    rgb_to_cie_xy_chromaticity_checker i_checker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_data (in_data),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    always #5 clk = ~clk;

    // Count cycles in which neither a request nor a result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Hold the request until busy is low at a rising edge.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        logic was_busy;
        start   <= 1'b1;
        in_data <= '{red: r, green: g, blue: b};
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Favor the curve boundary and the extremes.
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'(10 + $urandom_range(0, 1));
            3: return 8'($urandom_range(0, 12));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int burst;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        in_data     = '0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: black, white, primaries, segment boundary, single bits.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd10, 8'd10, 8'd10);
        send_pixel(8'd11, 8'd11, 8'd11);
        send_pixel(8'd10, 8'd11, 8'd12);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd1, 8'd1);
        for (int k = 0; k < 8; k++)
        begin
            send_pixel(8'(1 << k), 8'(1 << ((k + 3) % 8)), 8'(1 << ((k + 5) % 8)));
        end
        send_pixel(8'd0, 8'd0, 8'd0);

        for (int n = 0; n < N_RANDOM; )
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 12);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
            begin
                if (n == N_RANDOM / 2)
                begin
                    // Drain the pipeline once before going on.
                    start <= 1'b0;
                    while (pending != 0) @(posedge clk);
                end
                send_pixel(pick_channel(), pick_channel(), pick_channel());
            end
            pause_sender($urandom_range(0, 1) ? $urandom_range(1, 30) : 0);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
